// ===== design/gdod_pkg.sv =====
`default_nettype none
package gdod_pkg;

	// Largest year that a shifted date may reach.
	localparam int MAX_YEAR = 9999;

	// Field widths of the stream payloads.
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int OFF_W   = 23;
	localparam int DIFF_W  = 23;

	// Serial day numbers: any input date fits SER_W unsigned bits, the working
	// accumulator also holds a shifted date and the upper clamp limit, signed.
	localparam int SER_W = 23;
	localparam int ACC_W = 26;
	// Year counter: remaining years while encoding, result year while decoding.
	localparam int YC_W  = 17;

	// Replacement date for an invalid input.
	localparam int DEF_YEAR   = 2000;
	localparam int DEF_SERIAL = 365 * (DEF_YEAR - 1) + (DEF_YEAR - 1) / 4
		- (DEF_YEAR - 1) / 100 + (DEF_YEAR - 1) / 400 + 1;
	// Serial number of the last day of MAX_YEAR.
	localparam int SER_HI = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400;

	// Days and years in each block of the Gregorian cycle.
	localparam int DAYS_400 = 146097;
	localparam int DAYS_100 = 36524;
	localparam int DAYS_4   = 1461;
	localparam int DAYS_1   = 365;

	// Highest counts inside a 400-year cycle.
	localparam int LAST_C100 = 3;
	localparam int LAST_Q4   = 24;
	localparam int LAST_Y1   = 3;
	localparam int LAST_MONTH = 12;

	// Saturation limits of the difference.
	localparam int DIFF_MAX = (2 ** (DIFF_W - 1)) - 1;
	localparam int DIFF_MIN = -(2 ** (DIFF_W - 1));

	// Input beat layout, first field in the lowest bits.
	localparam int IN_YA   = 0;
	localparam int IN_MA   = IN_YA + YEAR_W;
	localparam int IN_DA   = IN_MA + MONTH_W;
	localparam int IN_YB   = IN_DA + DAY_W;
	localparam int IN_MB   = IN_YB + YEAR_W;
	localparam int IN_DB   = IN_MB + MONTH_W;
	localparam int IN_OFF  = IN_DB + DAY_W;
	localparam int IN_BITS = IN_OFF + OFF_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// Output beat layout.
	localparam int OUT_BITS   = YEAR_W + MONTH_W + DAY_W + DIFF_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W = 5;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_DEF, S_T400, S_T100, S_T4, S_T1, S_CHK, S_TMON,
		S_SAVE, S_CMP, S_SHIFT, S_CLAMP, S_F400, S_F100, S_F4, S_F1, S_FMON,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CAPTURE, OP_START, OP_DEFAULT, OP_YSTEP, OP_TMON, OP_SAVE,
		OP_CMP, OP_SHIFT, OP_CLAMP, OP_FSTEP, OP_FMON
	} op_t;

	typedef enum logic [1:0] {
		BLK_400, BLK_100, BLK_4, BLK_1
	} blk_t;

	// Sequencer commands to the datapath.
	typedef struct packed {
		op_t  op;
		blk_t blk;
		logic side_b;
		logic emit;
	} ctl_t;

	// Datapath conditions back to the sequencer.
	typedef struct packed {
		logic take;
		logic simple_bad;
		logic day_bad;
		logic func;
	} sts_t;

	// One finished result.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [DIFF_W-1:0]  diff;
		logic               after;
		logic               equal;
		logic               a_def;
		logic               b_def;
		logic               range_err;
	} res_t;

	// Leap year from the position inside the 400-year cycle.
	function automatic logic is_leap(input logic [1:0] c100, input logic [4:0] q4,
		input logic [1:0] y1);
		return (y1 == 2'(LAST_Y1)) && ((q4 != 5'(LAST_Q4)) || (c100 == 2'(LAST_C100)));
	endfunction

	// Length of a month; zero for codes that are no month.
	function automatic logic [DAY_W-1:0] month_days(input logic leap,
		input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2: d = leap ? 5'd29 : 5'd28;
			default: d = '0;
		endcase
		return d;
	endfunction

	function automatic logic [ACC_W-1:0] block_days(input blk_t b);
		logic [ACC_W-1:0] d;
		case (b)
			BLK_400: d = ACC_W'(DAYS_400);
			BLK_100: d = ACC_W'(DAYS_100);
			BLK_4:   d = ACC_W'(DAYS_4);
			default: d = ACC_W'(DAYS_1);
		endcase
		return d;
	endfunction

	function automatic logic [YC_W-1:0] block_years(input blk_t b);
		logic [YC_W-1:0] y;
		case (b)
			BLK_400: y = YC_W'(400);
			BLK_100: y = YC_W'(100);
			BLK_4:   y = YC_W'(4);
			default: y = YC_W'(1);
		endcase
		return y;
	endfunction

endpackage
`default_nettype wire

// ===== design/gdod_alu.sv =====
`default_nettype none
module gdod_alu (
	input  wire logic signed [gdod_pkg::ACC_W-1:0] a,
	input  wire logic signed [gdod_pkg::ACC_W-1:0] b,
	input  wire logic                              sub,
	output logic signed [gdod_pkg::ACC_W-1:0]      sum,
	output logic                                   neg,
	output logic                                   zero
);

	// Shared add/subtract with sign and zero flags for compares.
	always_comb begin
		sum  = sub ? (a - b) : (a + b);
		neg  = sum[gdod_pkg::ACC_W-1];
		zero = (sum == '0);
	end

endmodule
`default_nettype wire

// ===== design/gdod_dp.sv =====
`default_nettype none
module gdod_dp (
	input  wire logic                              clk,
	input  wire logic [gdod_pkg::IN_DATA_W-1:0]    in_data,
	input  wire logic                              in_func,
	input  wire gdod_pkg::ctl_t                    ctl,
	output gdod_pkg::sts_t                         sts,
	output gdod_pkg::res_t                         res
);

	localparam logic signed [gdod_pkg::ACC_W-1:0] HI_S =
		gdod_pkg::ACC_W'(gdod_pkg::SER_HI);
	localparam logic signed [gdod_pkg::ACC_W-1:0] DMAX_S =
		gdod_pkg::ACC_W'(gdod_pkg::DIFF_MAX);
	localparam logic signed [gdod_pkg::ACC_W-1:0] DMIN_S =
		gdod_pkg::ACC_W'(gdod_pkg::DIFF_MIN);

	// Captured input item.
	logic                              func_q;
	logic [gdod_pkg::YEAR_W-1:0]       ya_q, yb_q;
	logic [gdod_pkg::MONTH_W-1:0]      ma_q, mb_q;
	logic [gdod_pkg::DAY_W-1:0]        da_q, db_q;
	logic [gdod_pkg::OFF_W-1:0]        off_q;

	// Working state.
	logic signed [gdod_pkg::ACC_W-1:0] acc_q;
	logic [gdod_pkg::YC_W-1:0]         ycnt_q;
	logic [1:0]                        c_q, y1_q;
	logic [4:0]                        q4_q;
	logic [gdod_pkg::MONTH_W-1:0]      mon_q;
	logic [gdod_pkg::SER_W-1:0]        sa_q;
	logic                              a_def_q, b_def_q, after_q, eq_q, err_q;
	logic [gdod_pkg::DIFF_W-1:0]       diff_q;

	logic [gdod_pkg::YEAR_W-1:0]       y_cur;
	logic [gdod_pkg::MONTH_W-1:0]      m_cur;
	logic [gdod_pkg::DAY_W-1:0]        d_cur;
	logic                              leap;
	logic [gdod_pkg::DAY_W-1:0]        dim;
	logic [gdod_pkg::YC_W-1:0]         ystep;
	logic signed [gdod_pkg::ACC_W-1:0] opa, opb, sum;
	logic                              sub, neg, zero, take, step_en;
	logic signed [gdod_pkg::ACC_W-1:0] sa_ext, off_ext, dim_ext;
	logic                              t_low, t_high, d_high, d_low;

	// Date under work and its calendar facts.
	always_comb begin
		y_cur   = ctl.side_b ? yb_q : ya_q;
		m_cur   = ctl.side_b ? mb_q : ma_q;
		d_cur   = ctl.side_b ? db_q : da_q;
		leap    = gdod_pkg::is_leap(c_q, q4_q, y1_q);
		dim     = gdod_pkg::month_days(leap, mon_q);
		ystep   = gdod_pkg::block_years(ctl.blk);
		sa_ext  = {{(gdod_pkg::ACC_W-gdod_pkg::SER_W){1'b0}}, sa_q};
		off_ext = {{(gdod_pkg::ACC_W-gdod_pkg::OFF_W){off_q[gdod_pkg::OFF_W-1]}}, off_q};
		dim_ext = {{(gdod_pkg::ACC_W-gdod_pkg::DAY_W){1'b0}}, dim};
	end

	// Operand selection for the shared adder.
	always_comb begin
		opa = acc_q;
		opb = '0;
		sub = 1'b0;
		case (ctl.op)
			gdod_pkg::OP_YSTEP: opb = gdod_pkg::block_days(ctl.blk);
			gdod_pkg::OP_TMON:  opb = dim_ext;
			gdod_pkg::OP_CMP: begin
				opa = sa_ext;
				opb = acc_q;
				sub = 1'b1;
			end
			gdod_pkg::OP_SHIFT: begin
				opa = sa_ext;
				opb = off_ext;
			end
			gdod_pkg::OP_CLAMP: begin
				opb = gdod_pkg::ACC_W'(1);
				sub = 1'b1;
			end
			gdod_pkg::OP_FSTEP: begin
				opb = gdod_pkg::block_days(ctl.blk);
				sub = 1'b1;
			end
			gdod_pkg::OP_FMON: begin
				opb = dim_ext;
				sub = 1'b1;
			end
			default: ;
		endcase
	end

	gdod_alu u_alu (
		.a    (opa),
		.b    (opb),
		.sub  (sub),
		.sum  (sum),
		.neg  (neg),
		.zero (zero)
	);

	// Loop conditions of the current step.
	always_comb begin
		case (ctl.op)
			gdod_pkg::OP_YSTEP: take = (ycnt_q >= ystep);
			gdod_pkg::OP_TMON:  take = (mon_q < m_cur);
			gdod_pkg::OP_FSTEP: begin
				case (ctl.blk)
					gdod_pkg::BLK_100: take = !neg && (c_q != 2'(gdod_pkg::LAST_C100));
					gdod_pkg::BLK_1:   take = !neg && (y1_q != 2'(gdod_pkg::LAST_Y1));
					default:           take = !neg;
				endcase
			end
			gdod_pkg::OP_FMON:
				take = (mon_q != gdod_pkg::MONTH_W'(gdod_pkg::LAST_MONTH)) && !neg;
			default: take = 1'b0;
		endcase
		step_en = take && ((ctl.op == gdod_pkg::OP_YSTEP) || (ctl.op == gdod_pkg::OP_FSTEP));
	end

	// Range checks for the clamp and the difference.
	always_comb begin
		t_low  = acc_q[gdod_pkg::ACC_W-1] || (acc_q == '0);
		t_high = (acc_q > HI_S);
		d_high = (sum > DMAX_S);
		d_low  = (sum < DMIN_S);
	end

	assign sts.take       = take;
	assign sts.func       = func_q;
	assign sts.simple_bad = (y_cur == '0) || (m_cur == '0)
		|| (m_cur > gdod_pkg::MONTH_W'(gdod_pkg::LAST_MONTH)) || (d_cur == '0);
	assign sts.day_bad    = (d_cur > gdod_pkg::month_days(leap, m_cur));

	// Cycle counters track the position in the 400-year cycle.
	always_ff @(posedge clk) begin
		if (ctl.op == gdod_pkg::OP_START || ctl.op == gdod_pkg::OP_CLAMP) begin
			c_q  <= '0;
			q4_q <= '0;
			y1_q <= '0;
		end else if (step_en) begin
			case (ctl.blk)
				gdod_pkg::BLK_100: c_q  <= c_q + 2'd1;
				gdod_pkg::BLK_4:   q4_q <= q4_q + 5'd1;
				gdod_pkg::BLK_1:   y1_q <= y1_q + 2'd1;
				default: ;
			endcase
		end
	end

	// Main datapath registers.
	always_ff @(posedge clk) begin
		case (ctl.op)
			gdod_pkg::OP_CAPTURE: begin
				func_q  <= in_func;
				ya_q    <= in_data[gdod_pkg::IN_YA +: gdod_pkg::YEAR_W];
				ma_q    <= in_data[gdod_pkg::IN_MA +: gdod_pkg::MONTH_W];
				da_q    <= in_data[gdod_pkg::IN_DA +: gdod_pkg::DAY_W];
				yb_q    <= in_data[gdod_pkg::IN_YB +: gdod_pkg::YEAR_W];
				mb_q    <= in_data[gdod_pkg::IN_MB +: gdod_pkg::MONTH_W];
				db_q    <= in_data[gdod_pkg::IN_DB +: gdod_pkg::DAY_W];
				off_q   <= in_data[gdod_pkg::IN_OFF +: gdod_pkg::OFF_W];
				a_def_q <= 1'b0;
				b_def_q <= 1'b0;
			end
			gdod_pkg::OP_START: begin
				ycnt_q <= gdod_pkg::YC_W'(y_cur) - gdod_pkg::YC_W'(1);
				acc_q  <= gdod_pkg::ACC_W'(d_cur);
				mon_q  <= gdod_pkg::MONTH_W'(1);
			end
			gdod_pkg::OP_DEFAULT: begin
				acc_q <= gdod_pkg::ACC_W'(gdod_pkg::DEF_SERIAL);
				if (ctl.side_b) begin
					b_def_q <= 1'b1;
				end else begin
					a_def_q <= 1'b1;
				end
			end
			gdod_pkg::OP_YSTEP: begin
				if (take) begin
					acc_q  <= sum;
					ycnt_q <= ycnt_q - ystep;
				end
			end
			gdod_pkg::OP_TMON, gdod_pkg::OP_FMON: begin
				if (take) begin
					acc_q <= sum;
					mon_q <= mon_q + gdod_pkg::MONTH_W'(1);
				end
			end
			gdod_pkg::OP_SAVE: sa_q <= acc_q[gdod_pkg::SER_W-1:0];
			gdod_pkg::OP_CMP: begin
				after_q <= !neg && !zero;
				eq_q    <= zero;
				if (func_q) begin
					diff_q <= d_high ? DMAX_S[gdod_pkg::DIFF_W-1:0] :
						d_low ? DMIN_S[gdod_pkg::DIFF_W-1:0] : sum[gdod_pkg::DIFF_W-1:0];
					err_q  <= d_high || d_low;
				end else begin
					diff_q <= '0;
					err_q  <= 1'b0;
				end
			end
			gdod_pkg::OP_SHIFT: acc_q <= sum;
			gdod_pkg::OP_CLAMP: begin
				// Clamp into the legal range and turn the serial into a zero-based count.
				acc_q  <= t_low ? '0 : (t_high ? (HI_S - gdod_pkg::ACC_W'(1)) : sum);
				err_q  <= t_low || t_high;
				ycnt_q <= gdod_pkg::YC_W'(1);
				mon_q  <= gdod_pkg::MONTH_W'(1);
			end
			gdod_pkg::OP_FSTEP: begin
				if (take) begin
					acc_q  <= sum;
					ycnt_q <= ycnt_q + ystep;
				end
			end
			default: ;
		endcase
	end

	// Result fields: the shifted date, or the checked date A for a difference.
	always_comb begin
		if (func_q) begin
			res.year  = a_def_q ? gdod_pkg::YEAR_W'(gdod_pkg::DEF_YEAR) : ya_q;
			res.month = a_def_q ? gdod_pkg::MONTH_W'(1) : ma_q;
			res.day   = a_def_q ? gdod_pkg::DAY_W'(1) : da_q;
		end else begin
			res.year  = ycnt_q[gdod_pkg::YEAR_W-1:0];
			res.month = mon_q;
			res.day   = acc_q[gdod_pkg::DAY_W-1:0] + gdod_pkg::DAY_W'(1);
		end
		res.diff      = diff_q;
		res.after     = after_q;
		res.equal     = eq_q;
		res.a_def     = a_def_q;
		res.b_def     = b_def_q;
		res.range_err = err_q;
	end

endmodule
`default_nettype wire

// ===== design/gdod_ctrl.sv =====
`default_nettype none
module gdod_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_free,
	input  wire gdod_pkg::sts_t sts,
	output logic                in_ready,
	output gdod_pkg::ctl_t      ctl
);

	gdod_pkg::state_t state_q, state_d;
	logic             side_q;
	logic             accept;

	assign accept = in_valid && (state_q == gdod_pkg::S_IDLE);

	// State and date-side registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdod_pkg::S_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				side_q <= 1'b0;
			end else if (state_q == gdod_pkg::S_SAVE) begin
				side_q <= 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gdod_pkg::S_IDLE:  if (accept) state_d = gdod_pkg::S_LOAD;
			gdod_pkg::S_LOAD:  state_d = sts.simple_bad ? gdod_pkg::S_DEF : gdod_pkg::S_T400;
			gdod_pkg::S_T400:  if (!sts.take) state_d = gdod_pkg::S_T100;
			gdod_pkg::S_T100:  if (!sts.take) state_d = gdod_pkg::S_T4;
			gdod_pkg::S_T4:    if (!sts.take) state_d = gdod_pkg::S_T1;
			gdod_pkg::S_T1:    if (!sts.take) state_d = gdod_pkg::S_CHK;
			gdod_pkg::S_CHK:   state_d = sts.day_bad ? gdod_pkg::S_DEF : gdod_pkg::S_TMON;
			gdod_pkg::S_TMON: begin
				if (!sts.take) state_d = side_q ? gdod_pkg::S_CMP : gdod_pkg::S_SAVE;
			end
			gdod_pkg::S_DEF:   state_d = side_q ? gdod_pkg::S_CMP : gdod_pkg::S_SAVE;
			gdod_pkg::S_SAVE:  state_d = gdod_pkg::S_LOAD;
			gdod_pkg::S_CMP:   state_d = sts.func ? gdod_pkg::S_DONE : gdod_pkg::S_SHIFT;
			gdod_pkg::S_SHIFT: state_d = gdod_pkg::S_CLAMP;
			gdod_pkg::S_CLAMP: state_d = gdod_pkg::S_F400;
			gdod_pkg::S_F400:  if (!sts.take) state_d = gdod_pkg::S_F100;
			gdod_pkg::S_F100:  if (!sts.take) state_d = gdod_pkg::S_F4;
			gdod_pkg::S_F4:    if (!sts.take) state_d = gdod_pkg::S_F1;
			gdod_pkg::S_F1:    if (!sts.take) state_d = gdod_pkg::S_FMON;
			gdod_pkg::S_FMON:  if (!sts.take) state_d = gdod_pkg::S_DONE;
			gdod_pkg::S_DONE:  if (out_free) state_d = gdod_pkg::S_IDLE;
			default:           state_d = gdod_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready   = (state_q == gdod_pkg::S_IDLE);
		ctl.op     = gdod_pkg::OP_NONE;
		ctl.blk    = gdod_pkg::BLK_400;
		ctl.side_b = side_q;
		ctl.emit   = 1'b0;
		case (state_q)
			gdod_pkg::S_IDLE:  if (accept) ctl.op = gdod_pkg::OP_CAPTURE;
			gdod_pkg::S_LOAD:  ctl.op = gdod_pkg::OP_START;
			gdod_pkg::S_DEF:   ctl.op = gdod_pkg::OP_DEFAULT;
			gdod_pkg::S_T400:  ctl.op = gdod_pkg::OP_YSTEP;
			gdod_pkg::S_T100: begin
				ctl.op  = gdod_pkg::OP_YSTEP;
				ctl.blk = gdod_pkg::BLK_100;
			end
			gdod_pkg::S_T4: begin
				ctl.op  = gdod_pkg::OP_YSTEP;
				ctl.blk = gdod_pkg::BLK_4;
			end
			gdod_pkg::S_T1: begin
				ctl.op  = gdod_pkg::OP_YSTEP;
				ctl.blk = gdod_pkg::BLK_1;
			end
			gdod_pkg::S_TMON:  ctl.op = gdod_pkg::OP_TMON;
			gdod_pkg::S_SAVE:  ctl.op = gdod_pkg::OP_SAVE;
			gdod_pkg::S_CMP:   ctl.op = gdod_pkg::OP_CMP;
			gdod_pkg::S_SHIFT: ctl.op = gdod_pkg::OP_SHIFT;
			gdod_pkg::S_CLAMP: ctl.op = gdod_pkg::OP_CLAMP;
			gdod_pkg::S_F400:  ctl.op = gdod_pkg::OP_FSTEP;
			gdod_pkg::S_F100: begin
				ctl.op  = gdod_pkg::OP_FSTEP;
				ctl.blk = gdod_pkg::BLK_100;
			end
			gdod_pkg::S_F4: begin
				ctl.op  = gdod_pkg::OP_FSTEP;
				ctl.blk = gdod_pkg::BLK_4;
			end
			gdod_pkg::S_F1: begin
				ctl.op  = gdod_pkg::OP_FSTEP;
				ctl.blk = gdod_pkg::BLK_1;
			end
			gdod_pkg::S_FMON:  ctl.op = gdod_pkg::OP_FMON;
			gdod_pkg::S_DONE:  ctl.emit = out_free;
			default: ;
		endcase
	end

	// An accepted beat always starts with date A.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == gdod_pkg::S_LOAD) && !side_q)
		else $error("accepted item did not start on date A");

	// A finished result waits while the output register is occupied.
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdod_pkg::S_DONE) && !out_free |=> (state_q == gdod_pkg::S_DONE))
		else $error("result left before the output register was free");

	// Saving date A moves on to date B.
	a_save_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdod_pkg::S_SAVE) |=> (state_q == gdod_pkg::S_LOAD) && side_q)
		else $error("date B not started after saving date A");

	// The comparison only runs once both dates are encoded.
	a_cmp_side: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdod_pkg::S_CMP) |-> side_q)
		else $error("comparison reached before date B");

endmodule
`default_nettype wire

// ===== design/gregorian_date_offset_and_difference.sv =====
`default_nettype none
// Gregorian date shift and difference unit.
// Input beats arrive on the s_ channel: two dates A and B, a signed day offset and
// the operation in s_tuser (0 shift A by the offset, 1 days from B to A). Invalid
// dates are replaced by 2000-01-01 and flagged. One result beat per input beat
// leaves on the m_ channel with the shifted date (or the checked date A), the
// difference, and flags for order, equality, replacement and range clamping.
// Each date is turned into a serial day number by stepping one shared adder over
// 400-, 100-, 4- and 1-year blocks and then months; a shift walks the same
// blocks back down. Encoding a date takes N block steps for year - 1 (at most 53
// below year 10000, at most 69 for any input year) and one month step per month
// before it; an invalid date takes no longer. A shift walks back down the blocks
// and months for the result date. s_tready is high only while the unit is idle.
// The result sits in an output register; a new item is accepted while it waits.
// If m_tready stays low, the next finished result waits in the unit until the
// register frees. Reset clears the sequencer and the output valid.
module gregorian_date_offset_and_difference (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// year_a, month_a, day_a, year_b, month_b, day_b, offset, zero pad
	input  wire logic [gdod_pkg::IN_DATA_W-1:0]     s_tdata,
	// func
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// out_year, out_month, out_day, difference, zero pad
	output logic [gdod_pkg::OUT_DATA_W-1:0]         m_tdata,
	// a_after_b, dates_equal, a_defaulted, b_defaulted, range_error
	output logic [gdod_pkg::OUT_USER_W-1:0]         m_tuser
);

	gdod_pkg::ctl_t ctl;
	gdod_pkg::sts_t sts;
	gdod_pkg::res_t res;
	logic           out_free;
	logic           m_tvalid_q;
	logic [gdod_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [gdod_pkg::OUT_USER_W-1:0] m_tuser_q;

	assign out_free = !m_tvalid_q || m_tready;

	gdod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.ctl      (ctl)
	);

	gdod_dp u_dp (
		.clk     (clk),
		.in_data (s_tdata),
		.in_func (s_tuser),
		.ctl     (ctl),
		.sts     (sts),
		.res     (res)
	);

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output beat payload.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_tdata_q <= {{(gdod_pkg::OUT_DATA_W-gdod_pkg::OUT_BITS){1'b0}},
				res.diff, res.day, res.month, res.year};
			m_tuser_q <= {res.range_err, res.b_def, res.a_def, res.equal, res.after};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

// ===== tb/gregorian_date_offset_and_difference_tb.sv =====
`timescale 1ns / 100ps
module gregorian_date_offset_and_difference_tb;

	// Operation codes carried in s_tuser.
	localparam logic FN_SHIFT = 1'b0;
	localparam logic FN_DIFF  = 1'b1;

	// Result beat layout, first field in the lowest bits.
	localparam int OUT_MO = gdod_pkg::YEAR_W;
	localparam int OUT_DY = OUT_MO + gdod_pkg::MONTH_W;
	localparam int OUT_DF = OUT_DY + gdod_pkg::DAY_W;

	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES  = 2000;

	typedef struct {
		logic                              func;
		logic [gdod_pkg::YEAR_W-1:0]       year_a;
		logic [gdod_pkg::MONTH_W-1:0]      month_a;
		logic [gdod_pkg::DAY_W-1:0]        day_a;
		logic [gdod_pkg::YEAR_W-1:0]       year_b;
		logic [gdod_pkg::MONTH_W-1:0]      month_b;
		logic [gdod_pkg::DAY_W-1:0]        day_b;
		logic signed [gdod_pkg::OFF_W-1:0] offset;
		bit                                drain;
	} date_item_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [gdod_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [gdod_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [gdod_pkg::OUT_USER_W-1:0] m_tuser;

	date_item_t     items_pending[$];
	gdod_pkg::res_t results_due[$];
	date_item_t     cur_item;
	logic           offering = 1'b0;
	bit             drive_now;
	int             send_gap = 0;
	int             stall_left = 0;
	int             hold_left = 0;
	bit             hold_done = 0;
	int             beats_in = 0;
	int             results_seen = 0;
	int             items_total = 0;
	int             errors = 0;
	logic           calm;

	gregorian_date_offset_and_difference u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// No idling in a window in the middle of the run and in its last part.
	assign calm = (beats_in >= 600 && beats_in < 750) || (beats_in + 200 >= items_total);

	// Calendar arithmetic on serial day numbers, 0001-01-01 being day 1.
	function automatic logic leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint month_length(input longint y, input longint m);
		longint n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11: n = 30;
			2: n = leap_year(y) ? 29 : 28;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic longint serial_of(input longint y, input longint m, input longint d);
		longint p;
		longint s;
		p = y - 1;
		s = 365 * p + p / 4 - p / 100 + p / 400;
		for (longint k = 1; k < m; k++)
			s += month_length(y, k);
		return s + d;
	endfunction

	function automatic void date_of(input longint s, output longint y, output longint m,
		output longint d);
		longint n, q400, c100, q4, y1, r;
		n = s - 1;
		q400 = n / gdod_pkg::DAYS_400;
		r = n % gdod_pkg::DAYS_400;
		c100 = r / gdod_pkg::DAYS_100;
		if (c100 == 4)
			c100 = 3;
		r -= c100 * gdod_pkg::DAYS_100;
		q4 = r / gdod_pkg::DAYS_4;
		r %= gdod_pkg::DAYS_4;
		y1 = r / gdod_pkg::DAYS_1;
		if (y1 == 4)
			y1 = 3;
		r -= y1 * gdod_pkg::DAYS_1;
		y = 400 * q400 + 100 * c100 + 4 * q4 + y1 + 1;
		m = 1;
		while (m < 12 && r >= month_length(y, m)) begin
			r -= month_length(y, m);
			m++;
		end
		d = r + 1;
	endfunction

	// Returns 1 when the date is invalid and has been replaced by 2000-01-01.
	function automatic logic validate_date(input longint y, input longint m, input longint d,
		output longint s);
		if (y > 0 && m >= 1 && m <= 12 && d >= 1 && d <= month_length(y, m)) begin
			s = serial_of(y, m, d);
			return 1'b0;
		end
		s = serial_of(gdod_pkg::DEF_YEAR, 1, 1);
		return 1'b1;
	endfunction

	// Expected result beat for one input beat.
	function automatic gdod_pkg::res_t predict_date_result(input date_item_t it);
		longint sa, sb, t, hi, ry, rm, rd, gap;
		logic err;
		gdod_pkg::res_t r;
		err = 1'b0;
		gap = 0;
		r.a_def = validate_date(it.year_a, it.month_a, it.day_a, sa);
		r.b_def = validate_date(it.year_b, it.month_b, it.day_b, sb);
		if (it.func == FN_SHIFT) begin
			t = sa + longint'(it.offset);
			hi = serial_of(gdod_pkg::MAX_YEAR, 12, 31);
			if (t < 1) begin
				t = 1;
				err = 1'b1;
			end else if (t > hi) begin
				t = hi;
				err = 1'b1;
			end
			date_of(t, ry, rm, rd);
		end else begin
			date_of(sa, ry, rm, rd);
			gap = sa - sb;
			if (gap > gdod_pkg::DIFF_MAX) begin
				gap = gdod_pkg::DIFF_MAX;
				err = 1'b1;
			end else if (gap < gdod_pkg::DIFF_MIN) begin
				gap = gdod_pkg::DIFF_MIN;
				err = 1'b1;
			end
		end
		r.year = gdod_pkg::YEAR_W'(ry);
		r.month = gdod_pkg::MONTH_W'(rm);
		r.day = gdod_pkg::DAY_W'(rd);
		r.diff = gdod_pkg::DIFF_W'(gap);
		r.after = (sa > sb);
		r.equal = (sa == sb);
		r.range_err = err;
		return r;
	endfunction

	// Random date: always valid, with a share of years above MAX_YEAR; raw mode
	// takes any bit pattern of the fields.
	function automatic void pick_date(input bit raw, output int y, output int m, output int d);
		int roll;
		if (raw) begin
			y = $urandom_range(0, 16383);
			m = $urandom_range(0, 15);
			d = $urandom_range(0, 31);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 6)
				y = $urandom_range(10000, 16383);
			else if (roll < 12)
				y = $urandom_range(1, 400);
			else
				y = $urandom_range(1, 9999);
			m = $urandom_range(1, 12);
			d = $urandom_range(1, int'(month_length(y, m)));
		end
	endfunction

	task automatic add_item(input logic func, input int ya, input int ma, input int da,
		input int yb, input int mb, input int db, input int off, input bit drain = 0);
		date_item_t it;
		it.func = func;
		it.year_a = gdod_pkg::YEAR_W'(ya);
		it.month_a = gdod_pkg::MONTH_W'(ma);
		it.day_a = gdod_pkg::DAY_W'(da);
		it.year_b = gdod_pkg::YEAR_W'(yb);
		it.month_b = gdod_pkg::MONTH_W'(mb);
		it.day_b = gdod_pkg::DAY_W'(db);
		it.offset = gdod_pkg::OFF_W'(off);
		it.drain = drain;
		items_pending.push_back(it);
	endtask

	// Sender: offers the next pending beat at the falling edge, with random gaps.
	// A beat marked drain waits until every expected result has come back.
	always @(negedge clk) begin
		if (arst_n && !offering) begin
			drive_now = 1'b0;
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
			end else if (items_pending.size() != 0 &&
				!(items_pending[0].drain && results_due.size() != 0)) begin
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(0, 10);
				else
					drive_now = 1'b1;
			end
			if (drive_now) begin
				cur_item = items_pending[0];
				s_tdata <= gdod_pkg::IN_DATA_W'({cur_item.offset, cur_item.day_b,
					cur_item.month_b, cur_item.year_b, cur_item.day_a, cur_item.month_a,
					cur_item.year_a});
				s_tuser <= cur_item.func;
				offering <= 1'b1;
			end
			s_tvalid <= drive_now;
		end
	end

	// Receiver: random stall bursts, and one long hold-off early in the run.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && results_seen >= 30) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 10);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: checks each result beat against the oldest expectation, then
	// records the prediction for an input beat taken at the same edge.
	always @(posedge clk) begin : monitor
		gdod_pkg::res_t want;
		gdod_pkg::res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.year = m_tdata[OUT_MO-1:0];
				got.month = m_tdata[OUT_MO +: gdod_pkg::MONTH_W];
				got.day = m_tdata[OUT_DY +: gdod_pkg::DAY_W];
				got.diff = m_tdata[OUT_DF +: gdod_pkg::DIFF_W];
				got.after = m_tuser[0];
				got.equal = m_tuser[1];
				got.a_def = m_tuser[2];
				got.b_def = m_tuser[3];
				got.range_err = m_tuser[4];
				if (results_due.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat at %0t", $realtime);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (got.year != want.year || got.month != want.month ||
						got.day != want.day || got.diff != want.diff ||
						got.after != want.after || got.equal != want.equal ||
						got.a_def != want.a_def || got.b_def != want.b_def ||
						got.range_err != want.range_err) begin
						if (errors < 10) begin
							$display("mismatch at %0t: expected %0d-%0d-%0d diff %0d flags %b",
								$realtime, want.year, want.month, want.day,
								$signed(want.diff), {want.after, want.equal, want.a_def,
								want.b_def, want.range_err});
							$display("  got %0d-%0d-%0d diff %0d flags %b",
								got.year, got.month, got.day, $signed(got.diff),
								{got.after, got.equal, got.a_def, got.b_def, got.range_err});
						end
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				results_due.push_back(predict_date_result(cur_item));
				void'(items_pending.pop_front());
				offering <= 1'b0;
				beats_in++;
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int ya, ma, da, yb, mb, db, off, roll;
		logic func;

		// Month and year carries, leap days and the century rules.
		add_item(FN_SHIFT, 2000, 2, 28, 2000, 2, 28, 1);
		add_item(FN_SHIFT, 1900, 2, 28, 1900, 3, 1, 1);
		add_item(FN_SHIFT, 2024, 12, 31, 2024, 12, 31, 1);
		add_item(FN_SHIFT, 2024, 3, 1, 2023, 3, 1, -1);
		add_item(FN_SHIFT, 2023, 1, 31, 2023, 2, 28, 28);
		// Shifts at and beyond the ends of the year range; those that leave it are clamped.
		add_item(FN_SHIFT, 9999, 12, 31, 1, 1, 1, 1);
		add_item(FN_SHIFT, 1, 1, 1, 9999, 12, 31, -1);
		add_item(FN_SHIFT, 16383, 12, 31, 2000, 1, 1, 0);
		add_item(FN_SHIFT, 2000, 1, 1, 2000, 1, 1, 4194303);
		add_item(FN_SHIFT, 5000, 6, 15, 5000, 6, 15, -4194304);
		add_item(FN_SHIFT, 1, 1, 1, 1, 1, 1, 3652058);
		add_item(FN_SHIFT, 12345, 6, 30, 8191, 1, 31, -3000000);
		// Differences, saturating ones included.
		add_item(FN_DIFF, 16383, 12, 31, 1, 1, 1, 0);
		add_item(FN_DIFF, 1, 1, 1, 16383, 12, 31, 0);
		add_item(FN_DIFF, 2024, 3, 1, 2023, 3, 1, 0);
		add_item(FN_DIFF, 1999, 7, 4, 1999, 7, 4, 0);
		add_item(FN_DIFF, 9999, 12, 31, 10000, 1, 1, 0);
		// Invalid dates fall back to 2000-01-01.
		add_item(FN_DIFF, 0, 5, 5, 2000, 1, 1, 0);
		add_item(FN_DIFF, 2020, 13, 1, 2020, 0, 1, 0);
		add_item(FN_DIFF, 2020, 15, 31, 2020, 4, 31, 0);
		add_item(FN_DIFF, 2020, 1, 0, 2100, 2, 29, 0);
		add_item(FN_SHIFT, 2000, 2, 29, 2000, 2, 30, 365);
		add_item(FN_SHIFT, 1600, 2, 29, 1700, 2, 29, -36524);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			func = ($urandom_range(0, 1) == 0) ? FN_SHIFT : FN_DIFF;
			pick_date($urandom_range(0, 99) < 12, ya, ma, da);
			roll = $urandom_range(0, 99);
			if (roll < 20) begin
				yb = ya;
				mb = ma;
				db = da;
			end else begin
				pick_date(roll >= 88, yb, mb, db);
			end
			roll = $urandom_range(0, 99);
			if (roll < 40)
				off = int'($urandom_range(0, 800)) - 400;
			else if (roll < 70)
				off = int'($urandom_range(0, 200000)) - 100000;
			else if (roll < 90)
				off = int'($urandom);
			else if (roll < 95)
				off = 4194303 - int'($urandom_range(0, 1000));
			else
				off = int'($urandom_range(0, 1000)) - 4194304;
			add_item(func, ya, ma, da, yb, mb, db, off, i == 0 || i == 950 || i == 1400);
		end
		items_total = items_pending.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (items_pending.size() != 0 || offering)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("gregorian_date_offset_and_difference_tb: done, clean");
		else
			$display("gregorian_date_offset_and_difference_tb: done, errors");
		$finish;
	end

	// Watchdog.
	initial begin
		#40_000_000;
		$display("gregorian_date_offset_and_difference_tb: done, errors");
		$finish;
	end

endmodule
